// ===== rtl/bblt_pkg.sv =====
// Package for the byte-budget LRU table: request codes, widths, queue entry type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bblt_pkg;
  localparam int ENTRIES_DEF = 16;
  localparam int ID_W = 64;
  localparam int BYTES_W = 32;
  localparam int TOTAL_W = 36;
  localparam int MAX_EVICT = 15;

  localparam logic [1:0] REQ_REFRESH = 2'd0;
  localparam logic [1:0] REQ_DELETE  = 2'd1;
  localparam logic [1:0] REQ_LOOKUP  = 2'd2;
  localparam logic [1:0] REQ_INVALID = 2'd3;

  localparam logic KIND_EVICT = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [ID_W-1:0]    entry_id;
    logic [BYTES_W-1:0] entry_bytes;
    logic               bypass;
  } cmd_t;
endpackage
`default_nettype wire

// ===== rtl/bblt_front.sv =====
// Front end: accepts requests, classifies disabled/unknown ones, and queues them.
// Depends on bblt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bblt_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire [1:0]             in_req_type,
  input  wire [63:0]            in_entry_id,
  input  wire [31:0]            in_entry_bytes,
  input  wire [35:0]            byte_budget,
  output logic                  q_valid,
  output bblt_pkg::cmd_t        q_cmd,
  input  wire                   q_pop
);
  import bblt_pkg::*;
  // two-entry queue
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  cmd_t       cin;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = mem_r[rp_r];

  always_comb begin
    cin.req_type = in_req_type;
    cin.entry_id = in_entry_id;
    cin.entry_bytes = in_entry_bytes;
    cin.bypass = (byte_budget == '0) || (in_req_type == REQ_INVALID);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cin;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop && q_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> in_stall) else $error("no stall at full");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
endmodule
`default_nettype wire

// ===== rtl/bblt_back.sv =====
// Back end: searches the table, updates LRU ranks, evicts one per cycle unless stalled.
// Depends on bblt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bblt_back #(
  parameter int ENTRIES = bblt_pkg::ENTRIES_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_valid,
  input  bblt_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  input  wire [35:0]          byte_budget,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic                out_result_kind,
  output logic [63:0]         out_evicted_id,
  output logic                out_hit,
  output logic [35:0]         out_total_bytes,
  output logic                out_last
);
  import bblt_pkg::*;
  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = TOTAL_W + IW + 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_APPLY  = 3'd1;
  localparam logic [2:0] ST_EVICT  = 3'd2;
  localparam logic [2:0] ST_FINAL  = 3'd3;
  localparam logic [2:0] ST_FULLEV = 3'd4;

  logic [2:0]         state_r;
  cmd_t               cmd_r;
  logic               valid_r [ENTRIES];
  logic [ID_W-1:0]    id_r    [ENTRIES];
  logic [BYTES_W-1:0] bytes_r [ENTRIES];
  logic [IW-1:0]      rank_r  [ENTRIES];
  logic [SW-1:0]      total_r;
  logic [CW-1:0]      count_r;
  logic               hit_r;
  logic [3:0]         nev_r;

  // output register
  logic               ov_r, okind_r, ohit_r, olast_r;
  logic [ID_W-1:0]    oid_r;
  logic [TOTAL_W-1:0] otot_r;

  assign out_valid = ov_r;
  assign out_result_kind = okind_r;
  assign out_evicted_id = oid_r;
  assign out_hit = ohit_r;
  assign out_total_bytes = otot_r;
  assign out_last = olast_r;

  logic ofree;
  assign ofree = !ov_r || !out_stall;

  // match, oldest and free-slot search
  logic          m_hit, o_any, f_any;
  logic [IW-1:0] m_idx, o_idx, f_idx;
  always_comb begin
    m_hit = 1'b0; m_idx = '0; o_any = 1'b0; o_idx = '0; f_any = 1'b0; f_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && id_r[i] == cmd_r.entry_id) begin m_hit = 1'b1; m_idx = IW'(i); end
      if (valid_r[i] && rank_r[i] == '0) begin o_any = 1'b1; o_idx = IW'(i); end
      if (!valid_r[i]) begin f_any = 1'b1; f_idx = IW'(i); end
    end
  end

  logic [TOTAL_W-1:0] rep_total;
  assign rep_total = (total_r > SW'({TOTAL_W{1'b1}})) ? {TOTAL_W{1'b1}}
                                                     : total_r[TOTAL_W-1:0];
  logic over;
  assign over = total_r > SW'(byte_budget);

  // output register loads: full-table eviction, budget eviction, final result
  logic evict_go, full_ins, o_load;
  assign evict_go = over && count_r > CW'(1) && nev_r < 4'(MAX_EVICT) && o_any;
  assign full_ins = (cmd_r.req_type == REQ_REFRESH) && !m_hit && (count_r >= CW'(ENTRIES));
  assign o_load = ofree && (((state_r == ST_APPLY) && full_ins) ||
                            ((state_r == ST_EVICT) && evict_go) ||
                            (state_r == ST_FINAL));

  assign q_pop = (state_r == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
      total_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) valid_r[i] <= 1'b0;
    end else begin
      if (o_load) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (q_valid) begin
          cmd_r <= q_cmd;
          nev_r <= '0;
          state_r <= q_cmd.bypass ? ST_FINAL : ST_APPLY;
          hit_r <= 1'b0;
        end
        ST_APPLY: begin
          hit_r <= m_hit;
          if (cmd_r.req_type == REQ_REFRESH) begin
            if (m_hit) begin
              for (int j = 0; j < ENTRIES; j++)
                if (valid_r[j] && rank_r[j] > rank_r[m_idx]) rank_r[j] <= rank_r[j] - 1'b1;
              rank_r[m_idx] <= IW'(count_r - 1'b1);
              bytes_r[m_idx] <= cmd_r.entry_bytes;
              total_r <= total_r - SW'(bytes_r[m_idx]) + SW'(cmd_r.entry_bytes);
              state_r <= ST_EVICT;
            end else if (count_r >= CW'(ENTRIES)) begin
              if (ofree) begin
                okind_r <= KIND_EVICT; oid_r <= id_r[o_idx];
                ohit_r <= 1'b0; otot_r <= '0; olast_r <= 1'b0;
                valid_r[o_idx] <= 1'b0;
                for (int j = 0; j < ENTRIES; j++)
                  if (valid_r[j]) rank_r[j] <= rank_r[j] - 1'b1;
                total_r <= total_r - SW'(bytes_r[o_idx]);
                count_r <= count_r - 1'b1;
                nev_r <= 4'd1;
                state_r <= ST_FULLEV;
              end
            end else begin
              valid_r[f_idx] <= 1'b1;
              id_r[f_idx] <= cmd_r.entry_id;
              bytes_r[f_idx] <= cmd_r.entry_bytes;
              rank_r[f_idx] <= IW'(count_r);
              count_r <= count_r + 1'b1;
              total_r <= total_r + SW'(cmd_r.entry_bytes);
              state_r <= ST_EVICT;
            end
          end else begin
            if (cmd_r.req_type == REQ_DELETE && m_hit) begin
              valid_r[m_idx] <= 1'b0;
              for (int j = 0; j < ENTRIES; j++)
                if (valid_r[j] && rank_r[j] > rank_r[m_idx]) rank_r[j] <= rank_r[j] - 1'b1;
              total_r <= total_r - SW'(bytes_r[m_idx]);
              count_r <= count_r - 1'b1;
            end
            state_r <= ST_FINAL;
          end
        end
        ST_FULLEV: begin
          // slot freed by the eviction; insert the new id
          valid_r[f_idx] <= 1'b1;
          id_r[f_idx] <= cmd_r.entry_id;
          bytes_r[f_idx] <= cmd_r.entry_bytes;
          rank_r[f_idx] <= IW'(count_r);
          count_r <= count_r + 1'b1;
          total_r <= total_r + SW'(cmd_r.entry_bytes);
          state_r <= ST_EVICT;
        end
        ST_EVICT: begin
          if (evict_go) begin
            if (ofree) begin
              okind_r <= KIND_EVICT; oid_r <= id_r[o_idx];
              ohit_r <= 1'b0; otot_r <= '0; olast_r <= 1'b0;
              valid_r[o_idx] <= 1'b0;
              for (int j = 0; j < ENTRIES; j++)
                if (valid_r[j]) rank_r[j] <= rank_r[j] - 1'b1;
              total_r <= total_r - SW'(bytes_r[o_idx]);
              count_r <= count_r - 1'b1;
              nev_r <= nev_r + 1'b1;
            end
          end else state_r <= ST_FINAL;
        end
        ST_FINAL: if (ofree) begin
          okind_r <= KIND_FINAL; oid_r <= '0;
          ohit_r <= hit_r; otot_r <= rep_total; olast_r <= 1'b1;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES)) else $error("count above capacity");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(oid_r) && $stable(olast_r)))
    else $error("result lost under stall");
  a_nev: assert property (@(posedge clk) disable iff (!rst_n)
    nev_r <= 4'(MAX_EVICT)) else $error("too many evictions");
  a_emp: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (total_r == '0)) else $error("total without entries");
endmodule
`default_nettype wire

// ===== rtl/byte_budget_lru_table_unit.sv =====
// Top level of the byte-budget LRU table: APB register, front queue, back engine.
// Depends on bblt_pkg, bblt_front, bblt_back.
//
// Usage: requests enter on the in_ channel (valid/stall), results leave on the
// out_ channel. Each refresh may give eviction transfers (kind 0), and every
// request ends with one final transfer (kind 1, last high) carrying hit and total.
// A refresh passes the apply, evict and final states, a delete or lookup passes
// apply and final, a bypassed request (zero budget or unknown type) goes straight
// to final; evictions (up to 15) and a full-table insert add steps of their own.
// The single back-end sequencer takes a new request only once the last has sent
// its final transfer, and sends evictions one per cycle unless the output stalls.
// A two-entry queue lets the front keep taking requests while the back works.
// When the receiver stalls, the output register holds and the back end waits.
// Reset (rst_n low, synchronous) empties the table, zeroes the total and the
// budget; a budget of zero gives only final transfers with hit 0.
// APB register 0 (byte_budget, 36 bits) lies at address 0; pready is always high.
`timescale 1ns / 1ps
`default_nettype none
module byte_budget_lru_table_unit #(
  parameter int ENTRIES = bblt_pkg::ENTRIES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire [1:0]   in_req_type,
  input  wire [63:0]  in_entry_id,
  input  wire [31:0]  in_entry_bytes,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_result_kind,
  output logic [63:0] out_evicted_id,
  output logic        out_hit,
  output logic [35:0] out_total_bytes,
  output logic        out_last,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire         paddr,
  input  wire [63:0]  pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import bblt_pkg::*;
  logic [TOTAL_W-1:0] budget_r;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {28'd0, budget_r} : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) budget_r <= '0;
    else if (psel && penable && pwrite && paddr == 1'b0) budget_r <= pwdata[TOTAL_W-1:0];
  end

  bblt_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_req_type, .in_entry_id, .in_entry_bytes,
    .byte_budget(budget_r), .q_valid, .q_cmd, .q_pop
  );

  bblt_back #(.ENTRIES(ENTRIES)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop, .byte_budget(budget_r),
    .out_valid, .out_stall, .out_result_kind, .out_evicted_id, .out_hit,
    .out_total_bytes, .out_last
  );
endmodule
`default_nettype wire

// ===== verif/tb_byte_budget_lru_table_unit.sv =====
// Testbench for byte_budget_lru_table_unit: random and directed requests, checked
// against a behavioral LRU table model held in a small scoreboard class.
// Depends on bblt_pkg and the RTL of byte_budget_lru_table_unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_byte_budget_lru_table_unit;
  import bblt_pkg::*;

  localparam int NSLOT = 16;
  localparam longint unsigned TOT_MAX = 64'hF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic        kind;
    logic [63:0] id;
    logic        hit;
    logic [35:0] total;
    logic        last;
  } lru_result_t;

  int n_errors = 0;

  task automatic report_mismatch(input string what);
    n_errors++;
    $display("%0t MISMATCH %s", $time, what);
  endtask

  class lru_scoreboard;
    logic [35:0]     budget;
    bit              valid_q[NSLOT];
    logic [63:0]     ids[NSLOT];
    logic [31:0]     sizes[NSLOT];
    int              rank[NSLOT];
    longint unsigned total;
    int              count;
    lru_result_t     pending[$];

    function new();
      budget = 0;
      total = 0;
      count = 0;
      foreach (valid_q[i]) valid_q[i] = 0;
    endfunction

    function logic [35:0] shown_total();
      return (total > TOT_MAX) ? 36'hF_FFFF_FFFF : total[35:0];
    endfunction

    function void push(logic k, logic [63:0] id, logic h, logic [35:0] t);
      lru_result_t r;
      r.kind = k; r.id = id; r.hit = h; r.total = t; r.last = k;
      pending.insert(pending.size(), r);
    endfunction

    function int find_oldest();
      foreach (valid_q[i]) if (valid_q[i] && rank[i] == 0) return i;
      return -1;
    endfunction

    function void drop(int s);
      valid_q[s] = 0;
      foreach (valid_q[j]) if (valid_q[j] && rank[j] > rank[s]) rank[j]--;
      total -= sizes[s];
      count--;
    endfunction

    function void note_request(logic [1:0] req, logic [63:0] id, logic [31:0] nbytes);
      int s, o, n;
      bit h;
      s = -1; n = 0;
      if (budget == 0 || req == REQ_INVALID) begin
        push(KIND_FINAL, 0, 0, shown_total());
        return;
      end
      foreach (valid_q[i]) if (s < 0 && valid_q[i] && ids[i] == id) s = i;
      h = (s >= 0);
      if (req == REQ_REFRESH) begin
        if (h) begin
          total -= sizes[s];
          foreach (valid_q[j]) if (valid_q[j] && rank[j] > rank[s]) rank[j]--;
          rank[s] = count - 1;
        end else begin
          if (count >= NSLOT) begin
            o = find_oldest();
            if (o >= 0) begin
              push(KIND_EVICT, ids[o], 0, 0);
              n++;
              drop(o);
            end
          end
          foreach (valid_q[i]) if (s < 0 && !valid_q[i]) s = i;
          valid_q[s] = 1; ids[s] = id; rank[s] = count; count++;
        end
        sizes[s] = nbytes;
        total += nbytes;
        while (total > budget && count > 1 && n < MAX_EVICT) begin
          o = find_oldest();
          push(KIND_EVICT, ids[o], 0, 0);
          n++;
          drop(o);
        end
      end else if (req == REQ_DELETE && h) begin
        drop(s);
      end
      push(KIND_FINAL, 0, h, shown_total());
    endfunction

    task check_result(lru_result_t got);
      lru_result_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected");
        return;
      end
      e = pending[0];
      pending.delete(0);
      if (got.kind !== e.kind) report_mismatch($sformatf("kind %0d exp %0d", got.kind, e.kind));
      if (got.id !== e.id) report_mismatch($sformatf("evicted_id %h exp %h", got.id, e.id));
      if (got.hit !== e.hit) report_mismatch($sformatf("hit %0d exp %0d", got.hit, e.hit));
      if (got.total !== e.total)
        report_mismatch($sformatf("total %h exp %h", got.total, e.total));
      if (got.last !== e.last) report_mismatch($sformatf("last %0d exp %0d", got.last, e.last));
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0;
  logic [1:0] in_req_type = 0;
  logic [63:0] in_entry_id = 0;
  logic [31:0] in_entry_bytes = 0;
  logic out_valid, in_stall, out_result_kind, out_hit, out_last, pready;
  logic [63:0] out_evicted_id, prdata;
  logic [35:0] out_total_bytes;
  logic psel = 0, penable = 0, pwrite = 0, paddr = 0;
  logic [63:0] pwdata = 0;
  bit quiet = 0;
  int cycles = 0;
  lru_scoreboard sb;

  byte_budget_lru_table_unit u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: sample at rising edge, stall in random bursts
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      lru_result_t r;
      r.kind = out_result_kind; r.id = out_evicted_id; r.hit = out_hit;
      r.total = out_total_bytes; r.last = out_last;
      sb.check_result(r);
    end
  end

  initial begin
    int b;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        b = $urandom_range(1, 3);
        out_stall = 1;
        repeat (b) @(negedge clk);
      end
      out_stall = 0;
      @(negedge clk);
    end
  end

  initial begin
    wait (cycles > CYCLE_LIMIT);
    $display("tb_byte_budget_lru_table_unit: FAIL");
    $finish;
  end

  task automatic write_budget(input logic [35:0] v);
    psel = 1; penable = 0; pwrite = 1; paddr = 0; pwdata = {28'd0, v};
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.budget = v;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic send_request(input logic [1:0] req, input logic [63:0] id,
                              input logic [31:0] nbytes);
    if (!quiet && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) @(negedge clk);
    in_valid = 1; in_req_type = req; in_entry_id = id; in_entry_bytes = nbytes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req, id, nbytes);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  logic [63:0] pool[8];

  function automatic logic [63:0] pick_id();
    if ($urandom_range(0, 9) < 8) return pool[$urandom_range(0, 7)] ^ $urandom_range(0, 19);
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] pick_size(int mode);
    case (mode)
      0: return $urandom_range(0, 200);
      1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [35:0] budgets[6];
    int r;
    sb = new();
    foreach (pool[i]) pool[i] = {$urandom, $urandom};
    pool[0] = 64'd0;
    pool[1] = 64'hFFFF_FFFF_FFFF_FFF0;
    repeat (2) @(negedge clk);
    rst_n = 1;
    // disabled table
    send_request(REQ_REFRESH, 64'd5, 32'd10);
    send_request(REQ_LOOKUP, 64'd5, 32'd0);
    drain();
    write_budget(36'd1000);
    // fill past capacity, then touch, delete, lookups, unknown type
    for (int i = 0; i < 18; i++) send_request(REQ_REFRESH, 64'd100 + i, 32'd1);
    send_request(REQ_REFRESH, 64'd105, 32'd50);
    send_request(REQ_LOOKUP, 64'd105, 32'd0);
    send_request(REQ_DELETE, 64'd105, 32'd0);
    send_request(REQ_DELETE, 64'd105, 32'd0);
    send_request(REQ_LOOKUP, 64'd999, 32'd0);
    send_request(REQ_INVALID, 64'd100 + 17, 32'd0);
    // one big refresh evicts many; id and size extremes
    send_request(REQ_REFRESH, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_REFRESH, 64'd0, 32'd0);
    drain();

    budgets[0] = 36'd300; budgets[1] = 36'd1;
    budgets[2] = 36'hF_FFFF_FFFF; budgets[3] = 36'd2000;
    budgets[4] = 36'h1_0000_0000; budgets[5] = 36'd0;
    for (int ph = 0; ph < 7; ph++) begin
      if (ph < 6) write_budget(budgets[ph]);
      else begin
        write_budget(36'd500);
        quiet = 1;
      end
      for (int k = 0; k < 60; k++) begin
        r = $urandom_range(0, 19);
        if (r < 12)
          send_request(REQ_REFRESH, pick_id(),
                       pick_size((budgets[ph % 6] > 36'hFFFF_FFFF) ? $urandom_range(0, 2)
                                 : ($urandom_range(0, 9) == 0 ? 1 : 0)));
        else if (r < 15) send_request(REQ_DELETE, pick_id(), $urandom);
        else if (r < 19) send_request(REQ_LOOKUP, pick_id(), $urandom);
        else send_request(REQ_INVALID, pick_id(), $urandom);
      end
      drain();
    end

    if (n_errors == 0 && sb.pending.size() == 0) begin
      $display("tb_byte_budget_lru_table_unit: PASS");
    end else begin
      $display("tb_byte_budget_lru_table_unit: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
